>>> design/ffba_pkg.sv
// ---------------------------------------------------------------------------
// ffba_pkg
// Shared types and constants of the first-fit block allocator.
// ---------------------------------------------------------------------------
package ffba_pkg;

  localparam int MaxBlocks   = 256;
  localparam int HeaderBytes = 16;
  localparam int IdxW        = $clog2(MaxBlocks);
  localparam int CntW        = $clog2(MaxBlocks + 1);
  localparam logic [24:0] SizeCap       = 25'h1000000;
  localparam logic [31:0] ResetBase     = 32'h0020_0000;
  localparam logic [24:0] ResetSize     = 25'h010_0000;

  localparam logic       OpAlloc = 1'b0;
  localparam logic       OpFree  = 1'b1;

  localparam logic [2:0] StOk      = 3'd0;
  localparam logic [2:0] StZero    = 3'd1;
  localparam logic [2:0] StNoMem   = 3'd2;
  localparam logic [2:0] StRange   = 3'd3;
  localparam logic [2:0] StNoStart = 3'd4;

  localparam logic CfgBase = 1'b0;
  localparam logic CfgSize = 1'b1;

  // one table entry
  typedef struct packed {
    logic [23:0] offset;
    logic [23:0] size;
    logic        is_free;
  } entry_t;

  typedef enum logic [3:0] {
    S_IDLE, S_SCAN_RD, S_SCAN_CHK, S_SPLIT_SH, S_SPLIT_WR,
    S_FREE_NX, S_FREE_PV, S_DEL_SH, S_SUM, S_DONE
  } state_t;

endpackage

>>> design/ffba_if.sv
// ---------------------------------------------------------------------------
// ffba_req_if / ffba_rsp_if / ffba_cfg_if
// Valid/ready channels of the allocator.
// ---------------------------------------------------------------------------
interface ffba_req_if;
  logic        valid;
  logic        ready;
  logic        op;
  logic [23:0] request_size;
  logic [31:0] address;
  modport source (output valid, op, request_size, address, input ready);
  modport sink   (input valid, op, request_size, address, output ready);
endinterface

interface ffba_rsp_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [31:0] granted_address;
  logic [23:0] granted_size;
  logic [23:0] free_bytes;
  logic [23:0] used_bytes;
  logic [8:0]  free_block_count;
  logic [8:0]  used_block_count;
  modport source (output valid, status, granted_address, granted_size, free_bytes,
                  used_bytes, free_block_count, used_block_count, input ready);
  modport sink   (input valid, status, granted_address, granted_size, free_bytes,
                  used_bytes, free_block_count, used_block_count, output ready);
endinterface

interface ffba_cfg_if;
  logic        valid;
  logic        ready;
  logic        index;
  logic [31:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

>>> design/ffba_table.sv
// ---------------------------------------------------------------------------
// ffba_table
// Block table memory: one write port, one registered read port.
// ---------------------------------------------------------------------------
module ffba_table (
  input  logic                  clk,
  input  logic                  we,
  input  logic [ffba_pkg::IdxW-1:0] waddr,
  input  ffba_pkg::entry_t      wdata,
  input  logic [ffba_pkg::IdxW-1:0] raddr,
  output ffba_pkg::entry_t      rdata
);
  ffba_pkg::entry_t mem [ffba_pkg::MaxBlocks];

  // write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

>>> design/first_fit_block_allocator.sv
// ---------------------------------------------------------------------------
// first_fit_block_allocator
// First-fit heap allocator with splitting and coalescing of free blocks.
// ---------------------------------------------------------------------------
// One request is handled at a time by a sequencer around a block table with
// one write and one registered read a cycle. A zero size or a null or
// out-of-range free goes straight to the totals sweep; otherwise a scan
// visits the entries in order, a split or a merge shifts the table tail one
// entry at a time, and the totals are rebuilt by a sweep over every block.
// The result sits in an output register, so the next request is taken while
// it waits; the sequencer only holds at the end of a request while an
// earlier result is still unread. A configuration beat is taken when idle
// with no result pending; writing heap_size rebuilds the table as one free
// block.
module first_fit_block_allocator (
  input logic clk,
  input logic rst,
  ffba_cfg_if.sink   cfg,
  ffba_req_if.sink   req,
  ffba_rsp_if.source rsp
);
  localparam int IW = ffba_pkg::IdxW;
  localparam int CW = ffba_pkg::CntW;
  localparam logic [23:0] Hdr = 24'(ffba_pkg::HeaderBytes);

  ffba_pkg::state_t state, state_next;

  logic [31:0] heap_base;
  logic [24:0] heap_size;
  logic [CW-1:0] block_count;
  ffba_pkg::entry_t entry0;         // entry 0 lives in flops after a rebuild
  logic          entry0_live;       // when set, entry 0 is read from entry0

  // request registers
  logic        op;
  logic [24:0] need;
  logic [23:0] rel;
  logic [CW-1:0] idx;       // scan / shift pointer
  logic [CW-1:0] k;         // block found
  ffba_pkg::entry_t cur;    // entry at k
  logic [23:0] acc;         // merged size under construction
  logic [2:0]  status;
  logic [31:0] gaddr;
  logic [23:0] gsize;
  logic [23:0] fsum, usum;
  logic [CW-1:0] fcnt, ucnt;
  logic        rd_ph;       // scan/shift phase: 0 issue read, 1 use data

  // result register
  logic        res_load;
  logic [2:0]  res_status;
  logic [31:0] res_gaddr;
  logic [23:0] res_gsize;
  logic [23:0] res_fsum, res_usum;
  logic [CW-1:0] res_fcnt, res_ucnt;

  // table port
  logic we;
  logic [IW-1:0] waddr, raddr;
  ffba_pkg::entry_t wdata, mrd, rd;

  ffba_table u_table (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(mrd)
  );

  logic [IW-1:0] raddr_q;
  always_ff @(posedge clk) raddr_q <= raddr;
  assign rd = (entry0_live && raddr_q == '0) ? entry0 : mrd;

  // free range check
  logic [32:0] lo, a_off;
  assign lo    = {1'b0, heap_base} + 33'(ffba_pkg::HeaderBytes);
  assign a_off = {1'b0, req.address} - lo;

  // configuration wins over a request in the same cycle
  assign cfg.ready = (state == ffba_pkg::S_IDLE) && !rsp.valid;
  assign req.ready = (state == ffba_pkg::S_IDLE) && !cfg.valid;

  assign res_load = (state == ffba_pkg::S_DONE) && (!rsp.valid || rsp.ready);

  logic [24:0] cap_size;
  assign cap_size = (cfg.data[24:0] > ffba_pkg::SizeCap) ? ffba_pkg::SizeCap
                                                          : cfg.data[24:0];

  // next state and table port
  always_comb begin
    state_next = state;
    we    = 1'b0;
    waddr = idx[IW-1:0];
    wdata = rd;
    raddr = idx[IW-1:0];
    case (state)
      ffba_pkg::S_IDLE: begin
        raddr = '0;
        if (req.valid && req.ready) begin
          if (req.op == ffba_pkg::OpAlloc) begin
            state_next = (req.request_size == '0) ? ffba_pkg::S_SUM
                                                  : ffba_pkg::S_SCAN_RD;
          end else begin
            state_next = (req.address == '0 || a_off[32]
                          || a_off >= {8'd0, heap_size}) ? ffba_pkg::S_SUM
                                                         : ffba_pkg::S_SCAN_RD;
          end
        end
      end
      ffba_pkg::S_SCAN_RD: begin
        state_next = (idx >= block_count) ? ffba_pkg::S_SUM : ffba_pkg::S_SCAN_CHK;
      end
      ffba_pkg::S_SCAN_CHK: begin
        if ((op == ffba_pkg::OpAlloc && rd.is_free && {1'b0, rd.size} >= need)
            || (op == ffba_pkg::OpFree && rd.offset == rel)) begin
          if (op == ffba_pkg::OpAlloc) begin
            if ({1'b0, rd.size} > need + {1'b0, Hdr}
                && block_count < CW'(ffba_pkg::MaxBlocks)) begin
              state_next = ffba_pkg::S_SPLIT_SH;
            end else begin
              we = 1'b1; waddr = idx[IW-1:0];
              wdata = '{offset: rd.offset, size: rd.size, is_free: 1'b0};
              state_next = ffba_pkg::S_SUM;
            end
          end else begin
            we = 1'b1; waddr = idx[IW-1:0];
            wdata = '{offset: rd.offset, size: rd.size, is_free: 1'b1};
            state_next = ffba_pkg::S_FREE_NX;
          end
        end else begin
          state_next = ffba_pkg::S_SCAN_RD;
        end
      end
      // move entries up one place from the tail down to k+1, a read then a write each
      ffba_pkg::S_SPLIT_SH: begin
        raddr = IW'(idx - 1'b1);
        if (idx == k + 1'b1) begin
          state_next = ffba_pkg::S_SPLIT_WR;
        end else if (rd_ph) begin
          we = 1'b1; waddr = idx[IW-1:0];
        end
      end
      ffba_pkg::S_SPLIT_WR: begin
        we = 1'b1; waddr = idx[IW-1:0];
        wdata = '{offset: 24'({1'b0, cur.offset} + {1'b0, Hdr} + need),
                  size: 24'({1'b0, cur.size} - need - {1'b0, Hdr}),
                  is_free: 1'b1};
        if (rd_ph) begin
          waddr = k[IW-1:0];
          wdata = '{offset: cur.offset, size: need[23:0], is_free: 1'b0};
          state_next = ffba_pkg::S_SUM;
        end
      end
      // look at the next entry
      ffba_pkg::S_FREE_NX: begin
        raddr = IW'(k + 1'b1);
        if (rd_ph) begin
          if (k + 1'b1 < block_count && rd.is_free) begin
            we = 1'b1; waddr = k[IW-1:0];
            wdata = '{offset: cur.offset, size: cur.size + Hdr + rd.size, is_free: 1'b1};
            state_next = ffba_pkg::S_DEL_SH;
          end else begin
            state_next = ffba_pkg::S_FREE_PV;
          end
        end
      end
      ffba_pkg::S_FREE_PV: begin
        raddr = IW'(k - 1'b1);
        if (rd_ph) begin
          if (k != '0 && rd.is_free) begin
            we = 1'b1; waddr = IW'(k - 1'b1);
            wdata = '{offset: rd.offset, size: rd.size + Hdr + acc, is_free: 1'b1};
            state_next = ffba_pkg::S_DEL_SH;
          end else begin
            state_next = ffba_pkg::S_SUM;
          end
        end
      end
      // remove entry idx: pull entries down one place; after a merge with
      // the next block, k still marks a block that may have a free previous
      ffba_pkg::S_DEL_SH: begin
        raddr = IW'(idx + 1'b1);
        if (idx + 1'b1 >= block_count) begin
          state_next = (op == ffba_pkg::OpFree && k != '0) ? ffba_pkg::S_FREE_PV
                                                           : ffba_pkg::S_SUM;
        end else if (rd_ph) begin
          we = 1'b1; waddr = idx[IW-1:0];
        end
      end
      ffba_pkg::S_SUM: begin
        state_next = (idx >= block_count && rd_ph) ? ffba_pkg::S_DONE : ffba_pkg::S_SUM;
      end
      ffba_pkg::S_DONE: state_next = res_load ? ffba_pkg::S_IDLE : ffba_pkg::S_DONE;
      default: state_next = ffba_pkg::S_IDLE;
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (rst) state <= ffba_pkg::S_IDLE;
    else     state <= state_next;
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      heap_base   <= ffba_pkg::ResetBase;
      heap_size   <= ffba_pkg::ResetSize;
      block_count <= CW'(1);
      entry0      <= '{offset: '0, size: 24'(ffba_pkg::ResetSize) - Hdr, is_free: 1'b1};
      entry0_live <= 1'b1;
      fsum <= 24'(ffba_pkg::ResetSize) - Hdr; usum <= '0;
      fcnt <= CW'(1); ucnt <= '0;
      rd_ph <= 1'b0;
    end else begin
      if (we && waddr == '0) entry0_live <= 1'b0;
      if (cfg.valid && cfg.ready) begin
        if (cfg.index == ffba_pkg::CfgBase) begin
          heap_base <= cfg.data;
        end else begin
          heap_size   <= cap_size;
          block_count <= CW'(1);
          entry0_live <= 1'b1;
          entry0 <= '{offset: '0,
                      size: (cap_size > 25'(ffba_pkg::HeaderBytes))
                            ? 24'(cap_size - 25'(ffba_pkg::HeaderBytes)) : '0,
                      is_free: 1'b1};
        end
      end
      case (state)
        ffba_pkg::S_IDLE: begin
          rd_ph <= 1'b0;
          if (req.valid && req.ready) begin
            op <= req.op; need <= ({1'b0, req.request_size} + 25'd3) & ~25'd3;
            rel <= a_off[23:0]; idx <= '0;
            gaddr <= '0; gsize <= '0;
            status <= (req.op == ffba_pkg::OpAlloc)
                ? ((req.request_size == '0) ? ffba_pkg::StZero : ffba_pkg::StNoMem)
                : ((req.address == '0 || a_off[32] || a_off >= {8'd0, heap_size})
                   ? ffba_pkg::StRange : ffba_pkg::StNoStart);
          end
        end
        ffba_pkg::S_SCAN_RD: if (idx >= block_count) idx <= '0;
        ffba_pkg::S_SCAN_CHK: begin
          if (state_next == ffba_pkg::S_SCAN_RD) begin
            idx <= idx + 1'b1;
          end else begin
            k <= idx; cur <= rd; acc <= rd.size;
            status <= ffba_pkg::StOk;
            if (op == ffba_pkg::OpAlloc) begin
              gaddr <= heap_base + {8'd0, rd.offset} + 32'(ffba_pkg::HeaderBytes);
              gsize <= (state_next == ffba_pkg::S_SPLIT_SH) ? need[23:0] : rd.size;
              idx   <= (state_next == ffba_pkg::S_SPLIT_SH) ? block_count : '0;
            end else begin
              gsize <= rd.size;
            end
            rd_ph <= 1'b0;
          end
        end
        ffba_pkg::S_SPLIT_SH: begin
          if (idx == k + 1'b1) begin
            rd_ph <= 1'b0;
            block_count <= block_count + 1'b1;
          end else begin
            rd_ph <= !rd_ph;
            if (rd_ph) idx <= idx - 1'b1;
          end
        end
        ffba_pkg::S_SPLIT_WR: begin
          rd_ph <= !rd_ph;
          if (rd_ph) idx <= '0;
        end
        ffba_pkg::S_FREE_NX: begin
          rd_ph <= !rd_ph;
          if (rd_ph && state_next == ffba_pkg::S_DEL_SH) begin
            acc <= cur.size + Hdr + rd.size;
            idx <= k + 1'b1;
          end
        end
        ffba_pkg::S_FREE_PV: begin
          rd_ph <= !rd_ph;
          if (rd_ph) begin
            idx <= (state_next == ffba_pkg::S_DEL_SH) ? k : '0;
            k   <= '0;
          end
        end
        ffba_pkg::S_DEL_SH: begin
          if (idx + 1'b1 >= block_count) begin
            block_count <= block_count - 1'b1;
            rd_ph <= 1'b0;
            idx <= '0;
          end else begin
            rd_ph <= !rd_ph;
            if (rd_ph) idx <= idx + 1'b1;
          end
        end
        ffba_pkg::S_SUM: begin
          if (idx == '0 && !rd_ph) begin
            fsum <= '0; usum <= '0; fcnt <= '0; ucnt <= '0;
          end
          rd_ph <= !rd_ph;
          if (rd_ph) begin
            if (idx < block_count) begin
              if (rd.is_free) begin fsum <= fsum + rd.size; fcnt <= fcnt + 1'b1; end
              else begin usum <= usum + rd.size; ucnt <= ucnt + 1'b1; end
            end
            idx <= idx + 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  // result register: holds the beat until it is taken
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (res_load) begin
      rsp.valid  <= 1'b1;
      res_status <= status;
      res_gaddr  <= gaddr;
      res_gsize  <= gsize;
      res_fsum   <= fsum;
      res_usum   <= usum;
      res_fcnt   <= fcnt;
      res_ucnt   <= ucnt;
    end else if (rsp.ready) begin
      rsp.valid <= 1'b0;
    end
  end

  assign rsp.status           = res_status;
  assign rsp.granted_address  = res_gaddr;
  assign rsp.granted_size     = res_gsize;
  assign rsp.free_bytes       = res_fsum;
  assign rsp.used_bytes       = res_usum;
  assign rsp.free_block_count = 9'(res_fcnt);
  assign rsp.used_block_count = 9'(res_ucnt);

`ifndef SYNTH
  a_cnt: assert property (@(posedge clk) disable iff (rst)
    block_count != '0 && block_count <= CW'(ffba_pkg::MaxBlocks))
    else $error("block count out of range");
  a_busy: assert property (@(posedge clk) disable iff (rst)
    state != ffba_pkg::S_IDLE |-> !req.ready)
    else $error("ready while busy");
  a_done: assert property (@(posedge clk) disable iff (rst)
    state == ffba_pkg::S_DONE |=> rsp.valid)
    else $error("result lost");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && !rsp.ready |=> rsp.valid)
    else $error("result beat dropped while stalled");
`endif
endmodule

>>> dv/ffba_tb_if.sv
// ---------------------------------------------------------------------------
// ffba_tb_pkg
// Beat types used by the testbench queues.
// ---------------------------------------------------------------------------
package ffba_tb_pkg;
  timeunit 1ns;
  timeprecision 1ps;

  // one queued request beat
  typedef struct packed {
    logic        op;
    logic [23:0] request_size;
    logic [31:0] address;
  } alloc_req_t;

  // one expected response beat
  typedef struct packed {
    logic [2:0]  status;
    logic [31:0] granted_address;
    logic [23:0] granted_size;
    logic [23:0] free_bytes;
    logic [23:0] used_bytes;
    logic [8:0]  free_block_count;
    logic [8:0]  used_block_count;
  } alloc_rsp_t;
endpackage

>>> dv/tb_first_fit_block_allocator.sv
// ---------------------------------------------------------------------------
// tb_first_fit_block_allocator
// Drives allocate and free requests in phases separated by register writes,
// predicts each response with a behavioural heap table and checks every beat.
// ---------------------------------------------------------------------------
module tb_first_fit_block_allocator;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CycleLimit = 20000000;

  logic clk = 1'b0;
  logic rst = 1'b1;

  ffba_cfg_if cfg ();
  ffba_req_if req ();
  ffba_rsp_if rsp ();

  first_fit_block_allocator u_top (.clk(clk), .rst(rst), .cfg(cfg), .req(req), .rsp(rsp));

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // heap model
  logic [31:0] heap_base;
  logic [24:0] heap_size;
  logic [23:0] tbl_off  [ffba_pkg::MaxBlocks];
  logic [23:0] tbl_size [ffba_pkg::MaxBlocks];
  logic        tbl_free [ffba_pkg::MaxBlocks];
  int          tbl_count;
  logic [31:0] live_addrs [$];

  ffba_tb_pkg::alloc_req_t pending_reqs [$];
  ffba_tb_pkg::alloc_rsp_t expected_rsps [$];
  ffba_tb_pkg::alloc_req_t next_req;
  ffba_tb_pkg::alloc_rsp_t got_rsp, exp_rsp;
  bit          failed = 1'b0;
  bit          sender_hold = 1'b0;
  longint      cycles = 0;

  function automatic void rebuild_heap();
    tbl_off[0]  = '0;
    tbl_size[0] = (heap_size > ffba_pkg::HeaderBytes)
                  ? 24'(heap_size - ffba_pkg::HeaderBytes) : '0;
    tbl_free[0] = 1'b1;
    tbl_count   = 1;
  endfunction

  function automatic void drop_entry(int k);
    for (int i = k; i + 1 < tbl_count; i++) begin
      tbl_off[i] = tbl_off[i+1]; tbl_size[i] = tbl_size[i+1]; tbl_free[i] = tbl_free[i+1];
    end
    tbl_count--;
  endfunction

  // apply one request to the heap table and return the response it yields
  function automatic ffba_tb_pkg::alloc_rsp_t heap_apply(ffba_tb_pkg::alloc_req_t r);
    ffba_tb_pkg::alloc_rsp_t o;
    logic [25:0] need;
    int          hit;
    longint      lo, rel;
    o = '0;
    hit = -1;
    if (r.op == ffba_pkg::OpAlloc) begin
      if (r.request_size == '0) o.status = ffba_pkg::StZero;
      else begin
        need = (26'(r.request_size) + 26'd3) & ~26'd3;
        for (int i = 0; i < tbl_count; i++)
          if (hit < 0 && tbl_free[i] && tbl_size[i] >= need) hit = i;
        if (hit < 0) o.status = ffba_pkg::StNoMem;
        else begin
          if (tbl_size[hit] > need + ffba_pkg::HeaderBytes
              && tbl_count < ffba_pkg::MaxBlocks) begin
            for (int i = tbl_count; i > hit + 1; i--) begin
              tbl_off[i] = tbl_off[i-1]; tbl_size[i] = tbl_size[i-1];
              tbl_free[i] = tbl_free[i-1];
            end
            tbl_off[hit+1]  = 24'(tbl_off[hit] + ffba_pkg::HeaderBytes + need);
            tbl_size[hit+1] = 24'(tbl_size[hit] - need - ffba_pkg::HeaderBytes);
            tbl_free[hit+1] = 1'b1;
            tbl_size[hit]   = 24'(need);
            tbl_count++;
          end
          tbl_free[hit] = 1'b0;
          o.status = ffba_pkg::StOk;
          o.granted_address = heap_base + 32'(tbl_off[hit]) + 32'(ffba_pkg::HeaderBytes);
          o.granted_size = tbl_size[hit];
        end
      end
    end else begin
      lo = longint'(heap_base) + ffba_pkg::HeaderBytes;
      if (r.address == '0 || longint'(r.address) < lo ||
          longint'(r.address) - lo >= longint'(heap_size)) o.status = ffba_pkg::StRange;
      else begin
        rel = longint'(r.address) - lo;
        for (int i = 0; i < tbl_count; i++)
          if (hit < 0 && longint'(tbl_off[i]) == rel) hit = i;
        if (hit < 0) o.status = ffba_pkg::StNoStart;
        else begin
          o.status = ffba_pkg::StOk;
          o.granted_size = tbl_size[hit];
          tbl_free[hit] = 1'b1;
          if (hit + 1 < tbl_count && tbl_free[hit+1]) begin
            tbl_size[hit] = 24'(tbl_size[hit] + ffba_pkg::HeaderBytes + tbl_size[hit+1]);
            drop_entry(hit + 1);
          end
          if (hit > 0 && tbl_free[hit-1]) begin
            tbl_size[hit-1] = 24'(tbl_size[hit-1] + ffba_pkg::HeaderBytes + tbl_size[hit]);
            drop_entry(hit);
          end
        end
      end
    end
    // running totals
    for (int i = 0; i < tbl_count; i++)
      if (tbl_free[i]) begin
        o.free_bytes += tbl_size[i]; o.free_block_count++;
      end else begin
        o.used_bytes += tbl_size[i]; o.used_block_count++;
      end
    if (o.status == ffba_pkg::StOk && r.op == ffba_pkg::OpAlloc)
      live_addrs.push_back(o.granted_address);
    return o;
  endfunction

  function automatic void queue_req(logic op, logic [23:0] sz, logic [31:0] addr);
    pending_reqs.push_back('{op: op, request_size: sz, address: addr});
  endfunction

  // random request mix: mostly allocs and frees of live blocks, some noise
  task automatic queue_random(int n, int max_sz);
    int          pick, k;
    logic [31:0] a;
    for (int i = 0; i < n; i++) begin
      pick = $urandom_range(0, 99);
      if (pick < 50)
        queue_req(ffba_pkg::OpAlloc, 24'($urandom_range(1, max_sz)), 32'($urandom));
      else if (pick < 85 && live_addrs.size() > 0) begin
        k = $urandom_range(0, live_addrs.size() - 1);
        a = live_addrs[k];
        live_addrs.delete(k);
        queue_req(ffba_pkg::OpFree, 24'($urandom), a);
      end else if (pick < 90)
        queue_req(ffba_pkg::OpFree, '0, heap_base + 32'(ffba_pkg::HeaderBytes)
                  + (32'($urandom_range(0, 4095)) & ~32'd3));
      else if (pick < 95)
        queue_req(ffba_pkg::OpFree, '0, $urandom);
      else
        queue_req(ffba_pkg::OpAlloc, 24'($urandom), '0);
    end
  endtask

  // driver
  int burst_left = 0;
  int gap_left = 0;
  always @(posedge clk) begin
    if (rst) begin
      req.valid <= 1'b0;
      req.op <= ffba_pkg::OpAlloc;
      req.request_size <= '0;
      req.address <= '0;
    end else begin
      if (req.valid && req.ready) begin
        expected_rsps.push_back(heap_apply('{op: req.op, request_size: req.request_size,
                                              address: req.address}));
      end
      if (!(req.valid && !req.ready)) begin
        if (gap_left > 0) begin
          gap_left <= gap_left - 1;
          req.valid <= 1'b0;
        end else if (!sender_hold && pending_reqs.size() > 0) begin
          next_req = pending_reqs.pop_front();
          req.valid <= 1'b1;
          req.op <= next_req.op;
          req.request_size <= next_req.request_size;
          req.address <= next_req.address;
          if (burst_left == 0) begin
            burst_left <= $urandom_range(1, 20);
            gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
          end else burst_left <= burst_left - 1;
        end else req.valid <= 1'b0;
      end
    end
  end

  // monitor and receiver stall pattern
  logic [7:0] stall_pat = 8'hFF;
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (rst) begin
      rsp.ready <= 1'b0;
    end else begin
      if ($urandom_range(0, 63) == 0) stall_pat <= 8'($urandom) | 8'h11;
      else stall_pat <= {stall_pat[6:0], stall_pat[7]};
      rsp.ready <= stall_pat[0];
      if (rsp.valid && rsp.ready) begin
        got_rsp = '{rsp.status, rsp.granted_address, rsp.granted_size, rsp.free_bytes,
                    rsp.used_bytes, rsp.free_block_count, rsp.used_block_count};
        if (expected_rsps.size() == 0) begin
          $display("%0t: response with nothing expected, expected none actual %p",
                   $realtime, got_rsp);
          failed = 1'b1;
        end else begin
          exp_rsp = expected_rsps.pop_front();
          if (got_rsp !== exp_rsp) begin
            $display("%0t: mismatch expected %p actual %p", $realtime, exp_rsp, got_rsp);
            failed = 1'b1;
          end
        end
      end
    end
    if (cycles > CycleLimit) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // wait until every queued request has been answered
  task automatic drain();
    while (pending_reqs.size() > 0 || req.valid || expected_rsps.size() > 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_reg(logic idx, logic [31:0] val);
    cfg.valid <= 1'b1;
    cfg.index <= idx;
    cfg.data  <= val;
    @(posedge clk);
    while (!cfg.ready) @(posedge clk);
    cfg.valid <= 1'b0;
    if (idx == ffba_pkg::CfgBase) heap_base = val;
    else begin
      heap_size = (val[24:0] > ffba_pkg::SizeCap) ? ffba_pkg::SizeCap : val[24:0];
      rebuild_heap();
      live_addrs.delete();
    end
  endtask

  // frees are drawn from blocks already granted when a phase is queued;
  // stale addresses give a not-block-start answer or free an already free block
  initial begin
    cfg.valid = 1'b0; cfg.index = ffba_pkg::CfgBase; cfg.data = '0;
    heap_base = ffba_pkg::ResetBase;
    heap_size = ffba_pkg::ResetSize;
    rebuild_heap();
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: field extremes and every status
    queue_req(ffba_pkg::OpAlloc, '0, '0);
    queue_req(ffba_pkg::OpAlloc, 24'hFFFFFF, '1);
    queue_req(ffba_pkg::OpAlloc, 24'd1, '0);
    queue_req(ffba_pkg::OpAlloc, 24'd5, '0);
    queue_req(ffba_pkg::OpAlloc, 24'd64, '0);
    queue_req(ffba_pkg::OpFree, '0, '0);
    queue_req(ffba_pkg::OpFree, '0, 32'hFFFF_FFFF);
    queue_req(ffba_pkg::OpFree, '0, ffba_pkg::ResetBase + 32'd4);
    queue_req(ffba_pkg::OpFree, '0, ffba_pkg::ResetBase + 32'd24);
    queue_req(ffba_pkg::OpFree, '1, ffba_pkg::ResetBase + 32'd36);
    queue_req(ffba_pkg::OpFree, '0, ffba_pkg::ResetBase + 32'd36);
    queue_req(ffba_pkg::OpFree, '0, ffba_pkg::ResetBase + 32'd16);
    queue_req(ffba_pkg::OpFree, '0, ffba_pkg::ResetBase + 32'd56);
    queue_req(ffba_pkg::OpAlloc, 24'(ffba_pkg::ResetSize - ffba_pkg::HeaderBytes), '0);
    queue_req(ffba_pkg::OpFree, '0, ffba_pkg::ResetBase + 32'd16);
    drain();

    // random with the reset heap
    queue_random(500, 40000);
    // pause the sender until all answers are in
    while (pending_reqs.size() > 200) @(posedge clk);
    sender_hold = 1'b1;
    while (req.valid || expected_rsps.size() > 0) @(posedge clk);
    sender_hold = 1'b0;
    drain();

    // small heap, many tiny blocks to fill the table
    write_reg(ffba_pkg::CfgBase, 32'hFFFF_F000);
    write_reg(ffba_pkg::CfgSize, 32'd8192);
    queue_random(450, 24);
    drain();

    // tiny heap: payload zero
    write_reg(ffba_pkg::CfgSize, 32'd8);
    queue_req(ffba_pkg::OpAlloc, 24'd1, '0);
    queue_req(ffba_pkg::OpFree, '0, 32'hFFFF_F010);
    drain();

    // small and oversized size, extreme bases
    write_reg(ffba_pkg::CfgBase, 32'h0);
    write_reg(ffba_pkg::CfgSize, 32'd64);
    queue_random(100, 64);
    drain();
    write_reg(ffba_pkg::CfgBase, 32'hFFFF_FFFC);
    write_reg(ffba_pkg::CfgSize, 32'h01FF_FFFF);
    queue_req(ffba_pkg::OpFree, '0, 32'd12);
    queue_random(400, 24'hFFFFFF);
    drain();

    // base change keeps the table
    write_reg(ffba_pkg::CfgBase, 32'h1234_5678);
    write_reg(ffba_pkg::CfgSize, 32'h0000_4000);
    queue_random(200, 300);
    drain();
    write_reg(ffba_pkg::CfgBase, $urandom & ~32'd3);
    queue_random(280, 600);
    drain();

    if (!failed) $display("No mismatches found");
    else $display("Mismatches found");
    $finish;
  end
endmodule

>>> files.f
design/ffba_pkg.sv
design/ffba_if.sv
design/ffba_table.sv
design/first_fit_block_allocator.sv
dv/ffba_tb_if.sv
dv/tb_first_fit_block_allocator.sv
